[hw/rtl/sos_pkg.sv]
`timescale 1ns / 1ps

package sos_pkg;

  typedef enum logic [1:0] {
    ET_FP16 = 2'd0,
    ET_FP32 = 2'd1,
    ET_BF16 = 2'd2
  } elem_type_e;

  localparam logic [1:0]  CFG_ELEMENT_TYPE = 2'd0;
  localparam logic [1:0]  CFG_REDUCE_COUNT = 2'd1;

  localparam logic [1:0]  ELEMENT_TYPE_RESET = 2'd1;
  localparam logic [31:0] REDUCE_COUNT_RESET = 32'd1;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
  localparam logic [31:0] BF16_BIAS = 32'h0000_7FFF;

  // control that travels with an element
  typedef struct packed {
    logic       last;
    logic [1:0] etype;
  } item_ctrl_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] ex;
    s  = h[15];
    e  = h[14:10];
    m  = h[9:0];
    p  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = 10'(m << (4'd10 - p));
    ex = 8'd103 + 8'(p);
    if (e == 5'h1F) begin
      return {s, 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, ex, mn, 13'd0};
    end
    return {s, 8'(e) + 8'd112, m, 13'd0};
  endfunction

  function automatic logic [31:0] widen(input logic [31:0] raw, input logic [1:0] t);
    logic [31:0] w;
    unique case (t)
      ET_FP16: w = half_to_single(raw[15:0]);
      ET_BF16: w = {raw[15:0], 16'd0};
      default: w = raw;
    endcase
    return w;
  endfunction

  // round an exact square P * 2^(2E-300) to fp32
  function automatic logic [31:0] square_round(input logic [47:0] p, input logic [7:0] e,
                                               input logic nan, input logic inf);
    logic signed [11:0] s_norm;
    logic signed [11:0] s_sub;
    logic signed [11:0] s;
    logic        [5:0]  sc;
    logic        [11:0] base;
    logic        [97:0] sh;
    logic        [47:0] q;
    logic               g;
    logic               st;
    logic        [47:0] qr;
    logic        [33:0] bits;
    s_norm = p[47] ? 12'sd24 : 12'sd23;
    s_sub  = 12'sd151 - 12'(2 * {4'd0, e});
    if (s_norm >= s_sub) begin
      s    = s_norm;
      base = 12'(s_norm) + 12'(2 * {4'd0, e}) + 12'd23 - 12'd174;
    end else begin
      s    = s_sub;
      base = 12'd0;
    end
    if (s > 12'sd50) sc = 6'd50;
    else if (s < 12'sd0) sc = 6'd0;
    else sc = 6'(s);
    sh   = {p, 50'd0} >> sc;
    q    = sh[97:50];
    g    = sh[49];
    st   = |sh[48:0];
    qr   = q + 48'(g & (st | q[0]));
    bits = {base[10:0], 23'd0} + 34'(qr);
    if (nan) return FP32_QNAN;
    if (inf || bits >= 34'(FP32_INF)) return FP32_INF;
    return bits[31:0];
  endfunction

  // add of two non-negative fp32 values, round to nearest even, NaN made quiet
  function automatic logic [31:0] add_pos(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  d;
    logic [4:0]  dc;
    logic [53:0] tb;
    logic [26:0] bb;
    logic [27:0] sm;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [8:0]  er;
    logic [24:0] mr;
    logic [33:0] bits;
    if ((x[30:23] == 8'hFF && x[22:0] != 23'd0) || (y[30:23] == 8'hFF && y[22:0] != 23'd0))
      return FP32_QNAN;
    if (x[30:23] == 8'hFF || y[30:23] == 8'hFF) return FP32_INF;
    if (x[30:0] >= y[30:0]) begin
      a = x; b = y;
    end else begin
      a = y; b = x;
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    d  = ea - eb;
    dc = (d > 8'd27) ? 5'd27 : d[4:0];
    tb = {mb, 3'd0, 27'd0} >> dc;
    bb = {tb[53:28], tb[27] | (|tb[26:0])};
    sm = {1'b0, ma, 3'd0} + {1'b0, bb};
    if (sm[27]) begin
      mant = sm[27:4];
      g    = sm[3];
      st   = |sm[2:0];
      er   = {1'b0, ea} + 9'd1;
    end else begin
      mant = sm[26:3];
      g    = sm[2];
      st   = |sm[1:0];
      er   = {1'b0, ea};
    end
    mr   = {1'b0, mant} + 25'(g & (st | mant[0]));
    bits = {2'd0, er - 9'd1, 23'd0} + 34'(mr);
    if (bits >= 34'(FP32_INF)) return FP32_INF;
    return bits[31:0];
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] b);
    logic               s;
    logic        [7:0]  e;
    logic        [22:0] m;
    logic signed [9:0]  he;
    logic        [23:0] mm;
    logic        [4:0]  sh;
    logic        [47:0] t;
    logic        [14:0] hm;
    logic               g;
    logic               st;
    s  = b[31];
    e  = b[30:23];
    m  = b[22:0];
    he = $signed({2'b00, e}) - 10'sd112;
    mm = {1'b1, m};
    sh = 5'(10'sd14 - he);
    t  = {mm, 24'd0} >> sh;
    if (e == 8'hFF) begin
      return {s, 5'h1F, (m != 23'd0), (m != 23'd0) ? m[21:13] : 9'd0};
    end else if (he >= 10'sd31) begin
      return {s, 15'h7C00};
    end else if (he <= 10'sd0) begin
      if (he < -10'sd10) return {s, 15'd0};
      hm = t[38:24];
      g  = t[23];
      st = |t[22:0];
      return {s, hm + 15'(g & (st | hm[0]))};
    end
    hm = {he[4:0], m[22:13]};
    g  = m[12];
    st = |m[11:0];
    return {s, hm + 15'(g & (st | hm[0]))};
  endfunction

  function automatic logic [31:0] narrow(input logic [31:0] b, input logic [1:0] t);
    logic [31:0] bf;
    logic [31:0] r;
    bf = b + BF16_BIAS + {31'd0, b[16]};
    unique case (t)
      ET_FP16: r = {16'd0, single_to_half(b)};
      ET_BF16: r = {16'd0, bf[31:16]};
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/sos_square.sv]
`timescale 1ns / 1ps

// input register, widen + mantissa multiply, round to fp32
module sos_square (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [31:0]             in_bits_i,
  input  sos_pkg::item_ctrl_t     in_ctrl_i,
  output logic                    sq_valid_o,
  output logic [31:0]             sq_bits_o,
  output sos_pkg::item_ctrl_t     sq_ctrl_o,
  input  logic                    sq_take_i
);

  logic                a_v_q, p_v_q, sq_v_q;
  logic                a_free, p_free, sq_free;
  logic [31:0]         a_bits_q;
  sos_pkg::item_ctrl_t a_ctrl_q, p_ctrl_q, sq_ctrl_q;
  logic [47:0]         p_prod_q, p_prod_d;
  logic [7:0]          p_exp_q, p_exp_d;
  logic                p_nan_q, p_nan_d, p_inf_q, p_inf_d;
  logic [31:0]         sq_bits_q, sq_bits_d;
  logic [31:0]         wide;
  logic [23:0]         mant;

  assign sq_free    = !sq_v_q || sq_take_i;
  assign p_free     = !p_v_q || sq_free;
  assign a_free     = !a_v_q || p_free;
  assign in_ready_o = a_free;

  always_comb begin
    wide     = sos_pkg::widen(a_bits_q, a_ctrl_q.etype);
    mant     = {wide[30:23] != 8'd0, wide[22:0]};
    p_prod_d = mant * mant;
    p_exp_d  = (wide[30:23] == 8'd0) ? 8'd1 : wide[30:23];
    p_nan_d  = (wide[30:23] == 8'hFF) && (wide[22:0] != 23'd0);
    p_inf_d  = (wide[30:23] == 8'hFF) && (wide[22:0] == 23'd0);
    sq_bits_d = sos_pkg::square_round(p_prod_q, p_exp_q, p_nan_q, p_inf_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      p_v_q  <= 1'b0;
      sq_v_q <= 1'b0;
    end else begin
      if (a_free)  a_v_q  <= in_valid_i;
      if (p_free)  p_v_q  <= a_v_q;
      if (sq_free) sq_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && in_valid_i) begin
      a_bits_q <= in_bits_i;
      a_ctrl_q <= in_ctrl_i;
    end
    if (p_free && a_v_q) begin
      p_prod_q <= p_prod_d;
      p_exp_q  <= p_exp_d;
      p_nan_q  <= p_nan_d;
      p_inf_q  <= p_inf_d;
      p_ctrl_q <= a_ctrl_q;
    end
    if (sq_free && p_v_q) begin
      sq_bits_q <= sq_bits_d;
      sq_ctrl_q <= p_ctrl_q;
    end
  end

  assign sq_valid_o = sq_v_q;
  assign sq_bits_o  = sq_bits_q;
  assign sq_ctrl_o  = sq_ctrl_q;

endmodule

[hw/rtl/sos_accum.sv]
`timescale 1ns / 1ps

// fp32 accumulator; closing element parks the sum in a hold register
module sos_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sq_valid_i,
  input  logic [31:0]         sq_bits_i,
  input  sos_pkg::item_ctrl_t sq_ctrl_i,
  output logic                sq_take_o,
  output logic                h_valid_o,
  output logic [31:0]         h_bits_o,
  output logic [1:0]          h_type_o,
  input  logic                h_take_i
);

  logic [31:0] acc_q, acc_d;
  logic        h_v_q;
  logic [31:0] h_bits_q;
  logic [1:0]  h_type_q;
  logic        h_free;
  logic [31:0] sum;

  assign h_free    = !h_v_q || h_take_i;
  assign sq_take_o = sq_valid_i && (!sq_ctrl_i.last || h_free);

  always_comb begin
    sum   = sos_pkg::add_pos(acc_q, sq_bits_i);
    acc_d = acc_q;
    if (sq_take_o) acc_d = sq_ctrl_i.last ? 32'd0 : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 32'd0;
      h_v_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (sq_take_o && sq_ctrl_i.last) h_v_q <= 1'b1;
      else if (h_take_i)               h_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_take_o && sq_ctrl_i.last) begin
      h_bits_q <= sum;
      h_type_q <= sq_ctrl_i.etype;
    end
  end

  assign h_valid_o = h_v_q;
  assign h_bits_o  = h_bits_q;
  assign h_type_o  = h_type_q;

endmodule

[hw/rtl/sos_out.sv]
`timescale 1ns / 1ps

// format conversion into the output register
module sos_out (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        h_valid_i,
  input  logic [31:0] h_bits_i,
  input  logic [1:0]  h_type_i,
  output logic        h_take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o
);

  logic        o_v_q;
  logic [31:0] o_bits_q, o_bits_d;

  assign h_take_o = !o_v_q || out_ready_i;
  assign o_bits_d = sos_pkg::narrow(h_bits_i, h_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (h_take_o) begin
      o_v_q <= h_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_take_o && h_valid_i) o_bits_q <= o_bits_d;
  end

  assign out_valid_o = o_v_q;
  assign sum_bits_o  = o_bits_q;

endmodule

[hw/rtl/sum_of_squares_reduce_top.sv]
`timescale 1ns / 1ps
// Sum-of-squares reduction, fp32 accumulate.
// A closing element passes the input, product and square registers; its sum then
// passes the hold and output registers. Throughput: one element per cycle; the
// combinational fp32 add into the accumulator register is the loop that sets that
// rate. Stalls only when the result register and hold register are both full.
// Reset: async active low; accumulator +0, counter 0, type fp32, count 1.
module sum_of_squares_reduce_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // element stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] element_bits_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [1:0]          etype_q;
  logic [31:0]         count_q;
  logic [31:0]         cnt_q, cnt_inc, limit;
  logic                in_xfer;
  sos_pkg::item_ctrl_t in_ctrl;

  logic                sq_valid, sq_take;
  logic [31:0]         sq_bits;
  sos_pkg::item_ctrl_t sq_ctrl;
  logic                h_valid, h_take;
  logic [31:0]         h_bits;
  logic [1:0]          h_type;

  assign in_xfer = in_valid_i && in_ready_o;

  // element counter saturates; a count of zero behaves as one
  always_comb begin
    cnt_inc       = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
    limit         = (count_q == 32'd0) ? 32'd1 : count_q;
    in_ctrl.last  = (cnt_inc >= limit);
    in_ctrl.etype = etype_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q <= sos_pkg::ELEMENT_TYPE_RESET;
      count_q <= sos_pkg::REDUCE_COUNT_RESET;
      cnt_q   <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sos_pkg::CFG_ELEMENT_TYPE: etype_q <= cfg_wdata_i[1:0];
          sos_pkg::CFG_REDUCE_COUNT: count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_xfer) cnt_q <= in_ctrl.last ? 32'd0 : cnt_inc;
    end
  end

  sos_square u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_bits_i  (element_bits_i),
    .in_ctrl_i  (in_ctrl),
    .sq_valid_o (sq_valid),
    .sq_bits_o  (sq_bits),
    .sq_ctrl_o  (sq_ctrl),
    .sq_take_i  (sq_take)
  );

  sos_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sq_valid_i (sq_valid),
    .sq_bits_i  (sq_bits),
    .sq_ctrl_i  (sq_ctrl),
    .sq_take_o  (sq_take),
    .h_valid_o  (h_valid),
    .h_bits_o   (h_bits),
    .h_type_o   (h_type),
    .h_take_i   (h_take)
  );

  sos_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .h_valid_i   (h_valid),
    .h_bits_i    (h_bits),
    .h_type_i    (h_type),
    .h_take_o    (h_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sum_bits_o  (sum_bits_o)
  );

endmodule

[verif/sos_checker.sv]
`timescale 1ns / 1ps

module sos_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] element_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] sum_bits_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [31:0] INF  = 32'h7F80_0000;

  logic [31:0] acc_bits;
  logic [31:0] taken;
  logic [1:0]  cur_type;
  logic [31:0] cur_count;
  logic [31:0] sum_q[$];

  // value = sig * 2^e2, rounded to nearest even fp32 (non-negative)
  function automatic logic [31:0] fp32_round(input logic [63:0] sig, input int e2);
    int          msb;
    int          sh;
    int          k;
    int          be;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    if (sig == 64'd0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) msb = i;
    sh = msb - 23;
    if (-149 - e2 > sh) sh = -149 - e2;
    if (sh <= 0) begin
      m = sig << (-sh);
    end else if (sh < 64) begin
      m    = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end else if (sh == 64) begin
      m = (sig > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      m = 64'd0;
    end
    k = sh + e2;
    if (m[24]) begin
      m = m >> 1;
      k = k + 1;
    end
    if (!m[23]) return m[31:0];
    be = 150 + k;
    if (be >= 255) return INF;
    return {1'b0, 8'(be), m[22:0]};
  endfunction

  function automatic logic [31:0] fp32_square(input logic [31:0] v);
    logic [63:0] sig;
    int          ex;
    if (v[30:23] == 8'hFF) return (v[22:0] != 23'd0) ? QNAN : INF;
    sig = {40'd0, v[30:23] != 8'd0, v[22:0]};
    ex  = ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
    return fp32_round(sig * sig, 2 * ex);
  endfunction

  // both operands non-negative
  function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] st;
    int          ea;
    int          eb;
    int          et;
    int          d;
    if ((x[30:23] == 8'hFF && x[22:0] != 0) || (y[30:23] == 8'hFF && y[22:0] != 0))
      return QNAN;
    if (x[30:23] == 8'hFF || y[30:23] == 8'hFF) return INF;
    sa = {40'd0, x[30:23] != 8'd0, x[22:0]};
    sb = {40'd0, y[30:23] != 8'd0, y[22:0]};
    ea = ((x[30:23] == 8'd0) ? 1 : int'(x[30:23])) - 150;
    eb = ((y[30:23] == 8'd0) ? 1 : int'(y[30:23])) - 150;
    if (eb > ea) begin
      st = sa; sa = sb; sb = st;
      et = ea; ea = eb; eb = et;
    end
    d = ea - eb;
    // far below half an ulp: only a sticky bit is left of the smaller one
    if (d <= 30) return fp32_round((sa << d) + sb, eb);
    return fp32_round((sa << 3) | 64'd1, ea - 3);
  endfunction

  function automatic logic [31:0] from_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [31:0] e;
    logic [31:0] m;
    logic [31:0] ex;
    sgn = {h[15], 31'd0};
    e   = {27'd0, h[14:10]};
    m   = {22'd0, h[9:0]};
    ex  = 32'd113;
    if (e == 32'd31) return sgn | INF | (m << 13);
    if (e == 32'd0) begin
      if (m == 32'd0) return sgn;
      while (!m[10]) begin
        m  = m << 1;
        ex = ex - 32'd1;
      end
      return sgn | (ex << 23) | ((m & 32'h3FF) << 13);
    end
    return sgn | ((e + 32'd112) << 23) | (m << 13);
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic [15:0] sgn;
    int          he;
    int          sh;
    logic [31:0] m;
    logic [31:0] hm;
    logic [31:0] rem;
    logic [31:0] hw;
    sgn = {b[31], 15'd0};
    m   = {9'd0, b[22:0]};
    he  = int'(b[30:23]) - 112;
    if (b[30:23] == 8'hFF)
      return sgn | 16'h7C00 | ((m != 0) ? (16'h0200 | 16'(m >> 13)) : 16'd0);
    if (he >= 31) return sgn | 16'h7C00;
    if (he <= 0) begin
      if (he < -10) return sgn;
      m   = m | 32'h0080_0000;
      sh  = 14 - he;
      hm  = m >> sh;
      rem = m & ((32'd1 << sh) - 32'd1);
      hw  = 32'd1 << (sh - 1);
      if (rem > hw || (rem == hw && hm[0])) hm = hm + 32'd1;
      return sgn | hm[15:0];
    end
    hm  = (32'(he) << 10) | (m >> 13);
    rem = m & 32'h1FFF;
    if (rem > 32'h1000 || (rem == 32'h1000 && hm[0])) hm = hm + 32'd1;
    return sgn | hm[15:0];
  endfunction

  task automatic take_element(input logic [31:0] raw);
    logic [31:0] wide;
    logic [31:0] lim;
    logic [31:0] res;
    logic [31:0] bf;
    case (cur_type)
      sos_pkg::ET_FP16: wide = from_half(raw[15:0]);
      sos_pkg::ET_BF16: wide = {raw[15:0], 16'd0};
      default: wide = raw;
    endcase
    acc_bits = fp32_add(acc_bits, fp32_square(wide));
    if (acc_bits[30:23] == 8'hFF && acc_bits[22:0] != 23'd0) acc_bits = QNAN;
    if (taken != 32'hFFFF_FFFF) taken = taken + 32'd1;
    lim = (cur_count == 32'd0) ? 32'd1 : cur_count;
    if (taken >= lim) begin
      bf = acc_bits + 32'h7FFF + {31'd0, acc_bits[16]};
      case (cur_type)
        sos_pkg::ET_FP16: res = {16'd0, to_half(acc_bits)};
        sos_pkg::ET_BF16: res = {16'd0, bf[31:16]};
        default: res = acc_bits;
      endcase
      sum_q.push_back(res);
      acc_bits = 32'd0;
      taken    = 32'd0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: MISMATCH %s: got %08h expected %08h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_bits     = 32'd0;
      taken        = 32'd0;
      cur_type     = sos_pkg::ET_FP32;
      cur_count    = 32'd1;
      fail_count_o = 0;
      sum_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == sos_pkg::CFG_ELEMENT_TYPE) cur_type = cfg_wdata_i[1:0];
        else if (cfg_index_i == sos_pkg::CFG_REDUCE_COUNT) cur_count = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) take_element(element_bits_i);
      if (out_valid_i && out_ready_i) begin
        if (sum_q.size() == 0) report_mismatch("unexpected sum", sum_bits_i, 32'd0);
        else if (sum_bits_i !== sum_q[0]) report_mismatch("sum_bits", sum_bits_i, sum_q[0]);
        if (sum_q.size() != 0) void'(sum_q.pop_front());
      end
      pending_o = sum_q.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // type code with no format of its own; the block reads it as fp32
  localparam logic [1:0] ET_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;    // comfortably over the pipeline latency
  localparam int WATCHDOG_LIMIT = 4000; // longest quiet stretch is the receiver hold-off

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] elem = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sum_bits;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sos_pkg::CFG_ELEMENT_TYPE;
  logic [31:0] cfg_wdata = 32'd0;

  int fail_count;
  int pending;
  int hold_cycles = 0;  // receiver hold-off request
  bit calm = 1'b0;      // no random gaps or stalls on either side while set
  int quiet_cycles = 0;
  int n_sent = 0;

  always #5 clk_i = ~clk_i;

  sum_of_squares_reduce_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .element_bits_i(elem),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sum_bits_o    (sum_bits),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  sos_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .element_bits_i(elem),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .sum_bits_i    (sum_bits),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Result side: random stalls, or a counted hold-off when asked for one.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One element transfer; random gaps ahead of it unless calm.
  // Ready is read at the falling edge, where it is stable.
  task automatic send_element(input logic [31:0] d);
    bit ok;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    elem     <= d;
    do begin
      @(negedge clk_i);
      ok = in_ready;
      @(posedge clk_i);
    end while (!ok);
    n_sent++;
  endtask

  // Drop valid, let every expected sum come out, then let the pipe drain,
  // since a partial accumulation may still be in flight. The first edge
  // lets the checker count the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [1:0] t, input logic [31:0] cnt);
    settle();
    write_reg(sos_pkg::CFG_ELEMENT_TYPE, {30'd0, t});
    write_reg(sos_pkg::CFG_REDUCE_COUNT, cnt);
  endtask

  // Mostly well-scaled values so sums stay finite, some raw noise and specials.
  function automatic logic [31:0] gen_element(input logic [1:0] t);
    logic [31:0] r;
    int          sel;
    r   = $urandom();
    sel = $urandom_range(9);
    if (sel == 0) return r;
    if (sel == 1) begin
      case ($urandom_range(5))
        0: return (t == sos_pkg::ET_FP16) ? {r[31:16], 16'h7C00} :
                  (t == sos_pkg::ET_BF16) ? {r[31:16], 16'h7F80} : 32'h7F80_0000;
        1: return (t == sos_pkg::ET_FP16) ? {r[31:16], 16'h7E00} :
                  (t == sos_pkg::ET_BF16) ? {r[31:16], 16'h7FC0} : 32'h7FC0_0000;
        2: return {r[31:16], 16'h0001};
        3: return {r[31], 31'd0};
        4: return (t == sos_pkg::ET_FP16) ? {r[31:16], 16'h7BFF} : 32'h7F7F_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    case (t)
      sos_pkg::ET_FP16: return {r[31:15], 5'($urandom_range(30)), r[9:0]};
      sos_pkg::ET_BF16: return {r[31:15], 8'($urandom_range(90, 160)), r[6:0]};
      default: return {r[31], 8'($urandom_range(90, 160)), r[22:0]};
    endcase
  endfunction

  initial begin
    logic [1:0]  t;
    logic [31:0] cnt;
    int          n_items;
    int          phase;
    int          sel;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings are fp32, one element per sum.
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7F7F_FFFF);  // square overflows to infinity
    send_element(32'h0000_0001);  // square underflows to zero
    send_element(32'h7F80_0000);
    send_element(32'h7FC0_0001);  // NaN comes out as the canonical quiet NaN
    send_element(32'hFFFF_FFFF);
    configure(sos_pkg::ET_FP16, 32'd1);
    send_element(32'hFFFF_7BFF);  // largest half, high bits ignored
    send_element(32'h0000_0001);
    send_element(32'h0000_7C00);
    send_element(32'h0000_7E01);
    send_element(32'h0000_3C00);
    configure(sos_pkg::ET_BF16, 32'd1);
    send_element(32'h0000_7F7F);
    send_element(32'h0000_FFC1);
    send_element(32'h0000_3F80);
    configure(ET_SPARE, 32'd0);   // spare code reads as fp32, zero count as one
    send_element(32'h4000_0000);
    send_element(32'h3F80_0000);

    // Count lowered below what has already been taken.
    configure(sos_pkg::ET_FP32, 32'hFFFF_FFFF);
    send_element(32'h3F80_0000);
    send_element(32'h4000_0000);
    send_element(32'h4040_0000);
    settle();
    write_reg(sos_pkg::CFG_REDUCE_COUNT, 32'd2);
    send_element(32'h3F00_0000);

    // Type switched partway through a sum.
    configure(sos_pkg::ET_FP16, 32'd4);
    send_element(32'h0000_3C00);
    send_element(32'h0000_4000);
    settle();
    write_reg(sos_pkg::CFG_ELEMENT_TYPE, {30'd0, sos_pkg::ET_BF16});
    send_element(32'h0000_3F80);
    send_element(32'h0000_4040);

    // Backpressure: receiver holds off while elements keep coming.
    configure(sos_pkg::ET_FP32, 32'd1);
    calm        = 1'b1;
    hold_cycles = 300;
    repeat (40) send_element(gen_element(sos_pkg::ET_FP32));
    calm = 1'b0;

    // Random phases.
    phase = 0;
    while (n_sent < 540) begin
      t   = 2'($urandom_range(3));
      sel = $urandom_range(9);
      cnt = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd16 : 32'($urandom_range(1, 6));
      configure(t, cnt);
      calm    = (phase == 4) || (phase == 5);
      n_items = $urandom_range(10, 30);
      repeat (n_items) send_element(gen_element(t));
      calm = 1'b0;
      phase++;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sos_pkg.sv
hw/rtl/sos_square.sv
hw/rtl/sos_accum.sv
hw/rtl/sos_out.sv
hw/rtl/sum_of_squares_reduce_top.sv
verif/sos_checker.sv
verif/testbench.sv
